>>> design/cbd_pkg.sv
// shared types, constants and helpers for the constrained blend diffusion block
// no dependencies; compiled first
package cbd_pkg;

  localparam int PIX_BITS      = 16;
  localparam int NUM_PROJ      = 4;
  localparam int MAP_BITS      = 8;
  localparam int TAPS          = 5;
  localparam int MAX_WIDTH_DEF = 2048;
  localparam int MAX_HEIGHT    = 4096;
  localparam int CHANGE_LIMIT  = 32;
  localparam int SCALE60       = 60;
  localparam int SUM_BITS      = PIX_BITS + 3;
  localparam int WEIGHT_BITS   = 6;
  localparam int V60_BITS      = 24;
  localparam int DIV_NW        = 38;
  localparam int DIV_DW        = 24;
  localparam int DIV_QW        = PIX_BITS;
  localparam int CHAN_BITS     = 2;
  localparam int CNT_BITS      = 3;
  localparam int GEO_BITS      = 14;
  localparam int ROW_BITS      = 12;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 16;

  localparam logic [CFG_IDX_BITS-1:0] REG_MODE        = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_ACTIVE      = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_WIDTH       = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_HEIGHT      = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_CODE_NONE   = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_CODE_SINGLE = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_BLEND_MAX   = 3'd6;

  localparam logic MODE_SMOOTH = 1'b0;
  localparam logic MODE_BLEND  = 1'b1;

  localparam logic [2:0] TAP_OLD    = 3'd0;
  localparam logic [2:0] TAP_DOWN   = 3'd1;
  localparam logic [2:0] TAP_LEFT   = 3'd2;
  localparam logic [2:0] TAP_RIGHT  = 3'd3;
  localparam logic [2:0] TAP_CENTER = 3'd4;

  typedef struct packed {
    logic [MAP_BITS-1:0] map_code;
    logic [PIX_BITS-1:0] value_0;
    logic [PIX_BITS-1:0] value_1;
    logic [PIX_BITS-1:0] value_2;
    logic [PIX_BITS-1:0] value_3;
    logic [PIX_BITS-1:0] limit_0;
    logic [PIX_BITS-1:0] limit_1;
    logic [PIX_BITS-1:0] limit_2;
    logic [PIX_BITS-1:0] limit_3;
    logic [PIX_BITS-1:0] target_sum;
  } pix_in_t;

  typedef struct packed {
    logic [PIX_BITS-1:0] out_0;
    logic [PIX_BITS-1:0] out_1;
    logic [PIX_BITS-1:0] out_2;
    logic [PIX_BITS-1:0] out_3;
    logic                written;
    logic                frame_last;
    logic                updated;
  } pix_out_t;

  typedef logic [NUM_PROJ-1:0][PIX_BITS-1:0] lanes_t;

  typedef struct packed {
    logic [MAP_BITS-1:0] map;
    lanes_t              val;
  } line_word_t;

  typedef struct packed {
    lanes_t              lim;
    logic [PIX_BITS-1:0] sum;
  } lim_word_t;

  typedef struct packed {
    logic                 cap_in;
    logic                 rd_en;
    logic [2:0]           rd_tap;
    logic                 avg_start;
    logic                 avg_save;
    logic                 mul_en;
    logic                 scl_start;
    logic                 scl_save;
    logic                 chg_en;
    logic                 finish;
    logic                 out_load;
    logic [CHAN_BITS-1:0] chan;
  } cmd_t;

  typedef struct packed {
    logic                interior;
    logic                covered;
    logic                rescale;
    logic [CNT_BITS-1:0] na;
    logic                div_done;
    logic                div_busy;
  } sts_t;

  // 60 / tap count, so a sum times this weight is the average scaled by 60
  function automatic logic [WEIGHT_BITS-1:0] tap_weight(input logic [CNT_BITS-1:0] cnt);
    logic [WEIGHT_BITS-1:0] w;
    case (cnt)
      3'd1:    w = 6'd60;
      3'd2:    w = 6'd30;
      3'd3:    w = 6'd20;
      3'd4:    w = 6'd15;
      3'd5:    w = 6'd12;
      default: w = 6'd0;
    endcase
    return w;
  endfunction

endpackage

>>> design/cbd_if.sv
// request channel interfaces for pixels in and results out
// depends on cbd_pkg for the payload types
interface cbd_in_if;
  import cbd_pkg::*;
  logic    valid;
  logic    ready;
  pix_in_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface cbd_out_if;
  import cbd_pkg::*;
  logic     valid;
  logic     ready;
  pix_out_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

>>> design/cbd_div.sv
// iterative restoring divider, two quotient bits per cycle
// depends on cbd_pkg; quotient must fit in DIV_QW bits
module cbd_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [cbd_pkg::DIV_NW-1:0] dividend,
  input  logic [cbd_pkg::DIV_DW-1:0] divisor,
  output logic                       busy,
  output logic                       done,
  output logic [cbd_pkg::DIV_QW-1:0] quotient
);
  import cbd_pkg::*;

  localparam int XW     = DIV_DW + DIV_QW;
  localparam int STEPS  = 2;
  localparam int ROUNDS = DIV_QW / STEPS;
  localparam int RB     = $clog2(ROUNDS);

  logic [XW-1:0]     rem, rem_next, dsh, dsh_next;
  logic [DIV_QW-1:0] quo_next;
  logic [RB-1:0]     round;

  always_comb begin
    rem_next = rem;
    dsh_next = dsh;
    quo_next = quotient;
    for (int i = 0; i < STEPS; i++) begin
      if (rem_next >= dsh_next) begin
        rem_next = rem_next - dsh_next;
        quo_next = {quo_next[DIV_QW-2:0], 1'b1};
      end else begin
        quo_next = {quo_next[DIV_QW-2:0], 1'b0};
      end
      dsh_next = dsh_next >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      round <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        round <= '0;
        rem   <= XW'(dividend);
        dsh   <= XW'({divisor, {(DIV_QW-1){1'b0}}});
      end else if (busy) begin
        rem      <= rem_next;
        dsh      <= dsh_next;
        quotient <= quo_next;
        round    <= round + 1'b1;
        if (round == RB'(ROUNDS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> design/cbd_dp.sv
// datapath: config registers, line memories, taps, averaging, rescale and change tracking
// depends on cbd_pkg and cbd_div
module cbd_dp #(
  parameter int MAX_WIDTH = cbd_pkg::MAX_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [cbd_pkg::CFG_IDX_BITS-1:0]  cfg_idx,
  input  logic [cbd_pkg::CFG_DATA_BITS-1:0] cfg_data,
  input  cbd_pkg::pix_in_t                  in_data,
  output cbd_pkg::pix_out_t                 out_data,
  input  cbd_pkg::cmd_t                     cmd,
  output cbd_pkg::sts_t                     sts
);
  import cbd_pkg::*;

  localparam int CW      = $clog2(MAX_WIDTH);
  localparam int AW      = CW + 1;
  localparam int DEPTH_A = 2 * (2 ** CW);
  localparam int DEPTH_B = 2 ** CW;

  // configuration
  logic                mode;
  logic [2:0]          active_count;
  logic [11:0]         image_width;
  logic [12:0]         image_height;
  logic [MAP_BITS-1:0] code_none, code_single;
  logic [PIX_BITS-1:0] blend_max;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_BLEND;
      active_count <= 3'd4;
      image_width  <= 12'd2048;
      image_height <= 13'd1024;
      code_none    <= 8'd0;
      code_single  <= 8'd1;
      blend_max    <= 16'hFFFF;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_MODE:        mode         <= cfg_data[0];
        REG_ACTIVE:      active_count <= cfg_data[2:0];
        REG_WIDTH:       image_width  <= cfg_data[11:0];
        REG_HEIGHT:      image_height <= cfg_data[12:0];
        REG_CODE_NONE:   code_none    <= cfg_data[7:0];
        REG_CODE_SINGLE: code_single  <= cfg_data[7:0];
        REG_BLEND_MAX:   blend_max    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // geometry
  logic [GEO_BITS-1:0] w_eff, h_eff, col_g, row_g;
  logic [CNT_BITS-1:0] na;
  logic [CW-1:0]       col, colq;
  logic [ROW_BITS-1:0] row;
  logic                par, interior_q, row_end_q, frame_end_q;
  logic                row_end_c, frame_end_c, interior_c;

  always_comb begin
    if (image_width < 12'd3)
      w_eff = GEO_BITS'(3);
    else if (GEO_BITS'(image_width) > GEO_BITS'(MAX_WIDTH))
      w_eff = GEO_BITS'(MAX_WIDTH);
    else
      w_eff = GEO_BITS'(image_width);
    if (image_height < 13'd3)
      h_eff = GEO_BITS'(3);
    else if (GEO_BITS'(image_height) > GEO_BITS'(MAX_HEIGHT))
      h_eff = GEO_BITS'(MAX_HEIGHT);
    else
      h_eff = GEO_BITS'(image_height);
    if (active_count == 3'd0)
      na = CNT_BITS'(1);
    else if (active_count > CNT_BITS'(NUM_PROJ))
      na = CNT_BITS'(NUM_PROJ);
    else
      na = active_count;
    col_g       = GEO_BITS'(col);
    row_g       = GEO_BITS'(row);
    row_end_c   = (col_g + 1'b1) >= w_eff;
    frame_end_c = row_end_c && ((row_g + 1'b1) >= h_eff);
    interior_c  = (row_g >= GEO_BITS'(2)) && (row_g < h_eff) &&
                  (col_g >= GEO_BITS'(2)) && (col_g < w_eff);
  end

  // captured item
  logic [MAP_BITS-1:0] in_map;
  lanes_t              in_val, in_lim;
  logic [PIX_BITS-1:0] in_sum;

  // line memories
  line_word_t mema [DEPTH_A];
  lim_word_t  memb [DEPTH_B];
  line_word_t rda;
  lim_word_t  rdb;
  logic [AW-1:0] rd_addr;

  always_comb begin
    unique case (cmd.rd_tap)
      TAP_OLD:    rd_addr = {par, colq};
      TAP_DOWN:   rd_addr = {par, colq - CW'(1)};
      TAP_LEFT:   rd_addr = {~par, colq - CW'(2)};
      TAP_RIGHT:  rd_addr = {~par, colq};
      TAP_CENTER: rd_addr = {~par, colq - CW'(1)};
      default:    rd_addr = {par, colq};
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) mema[{par, colq}] <= '{map: in_map, val: in_val};
    if (cmd.rd_en) rda <= mema[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) memb[colq] <= '{lim: in_lim, sum: in_sum};
    if (cmd.rd_en && cmd.rd_tap == TAP_OLD) rdb <= memb[colq];
  end

  // tap registers and the entries displaced by the previous pixel
  logic                rd_q;
  logic [2:0]          tap_q;
  logic [MAP_BITS-1:0] tap_map [TAPS];
  lanes_t              tap_val [TAPS];
  logic [MAP_BITS-1:0] held_map;
  lanes_t              held_val, held_lim;
  logic [PIX_BITS-1:0] held_sum;

  always_ff @(posedge clk) begin
    if (rst) rd_q <= 1'b0;
    else     rd_q <= cmd.rd_en;
    tap_q <= cmd.rd_tap;
    if (rd_q) begin
      tap_map[tap_q] <= rda.map;
      tap_val[tap_q] <= rda.val;
    end
    if (cmd.finish) begin
      held_map <= tap_map[TAP_OLD];
      held_val <= tap_val[TAP_OLD];
      held_lim <= rdb.lim;
      held_sum <= rdb.sum;
    end
  end

  // cross average for the selected channel
  logic [TAPS-1:0]        cov;
  logic [CNT_BITS-1:0]    cnt;
  logic [PIX_BITS-1:0]    nv [TAPS];
  logic [SUM_BITS-1:0]    s;
  logic [V60_BITS-1:0]    sk, bm60, lim60, v60;
  logic [PIX_BITS-1:0]    lim_c, q, m0, jv_new;
  logic                   single;

  always_comb begin
    cov[0] = held_map != code_none;
    cov[1] = tap_map[TAP_DOWN] != code_none;
    cov[2] = tap_map[TAP_LEFT] != code_none;
    cov[3] = tap_map[TAP_RIGHT] != code_none;
    cov[4] = tap_map[TAP_CENTER] != code_none;
    cnt    = CNT_BITS'($countones(cov));
    nv[0]  = held_val[cmd.chan];
    nv[1]  = tap_val[TAP_DOWN][cmd.chan];
    nv[2]  = tap_val[TAP_LEFT][cmd.chan];
    nv[3]  = tap_val[TAP_RIGHT][cmd.chan];
    nv[4]  = tap_val[TAP_CENTER][cmd.chan];
    s = '0;
    for (int k = 0; k < TAPS; k++)
      if (cov[k]) s = s + SUM_BITS'(nv[k]);
    sk     = V60_BITS'(s) * V60_BITS'(tap_weight(cnt));
    bm60   = V60_BITS'(blend_max) * V60_BITS'(SCALE60);
    lim_c  = held_lim[cmd.chan];
    lim60  = V60_BITS'(lim_c) * V60_BITS'(SCALE60);
    v60    = (sk < bm60) ? sk : bm60;
    if (lim60 < v60) v60 = lim60;
    single = tap_map[TAP_CENTER] == code_single;
    m0     = (q < blend_max) ? q : blend_max;
    if (mode == MODE_SMOOTH)
      jv_new = single ? lim_c : m0;
    else
      jv_new = (m0 < lim_c) ? m0 : lim_c;
  end

  // shared divider: averages first, then the target sum rescale
  lanes_t                jv;
  logic [V60_BITS-1:0]   s60;
  logic [2*PIX_BITS-1:0] prod;
  logic [DIV_NW-1:0]     div_n;
  logic [DIV_DW-1:0]     div_d;
  logic                  div_busy, div_done;

  always_comb begin
    if (cmd.scl_start) begin
      // times 60 as 64 - 4
      div_n = (DIV_NW'(prod) << 6) - (DIV_NW'(prod) << 2);
      div_d = DIV_DW'(s60);
    end else begin
      div_n = DIV_NW'(s);
      div_d = DIV_DW'(cnt);
    end
  end

  cbd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.avg_start || cmd.scl_start),
    .dividend (div_n),
    .divisor  (div_d),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (q)
  );

  // largest change over active channels
  logic [PIX_BITS-1:0] chg_max, diff;
  logic [PIX_BITS-1:0] largest;

  always_comb begin
    chg_max = '0;
    for (int l = 0; l < NUM_PROJ; l++) begin
      diff = (jv[l] > tap_val[TAP_CENTER][l]) ? jv[l] - tap_val[TAP_CENTER][l]
                                              : tap_val[TAP_CENTER][l] - jv[l];
      if (CNT_BITS'(l) < na && diff > chg_max) chg_max = diff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col     <= '0;
      row     <= '0;
      largest <= '0;
    end else begin
      if (cmd.chg_en && chg_max > largest) largest <= chg_max;
      if (cmd.finish) begin
        if (row_end_q) begin
          col <= '0;
          if (frame_end_q) begin
            row     <= '0;
            largest <= '0;
          end else begin
            row <= row + 1'b1;
          end
        end else begin
          col <= colq + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      in_map      <= in_data.map_code;
      in_val      <= {in_data.value_3, in_data.value_2, in_data.value_1, in_data.value_0};
      in_lim      <= {in_data.limit_3, in_data.limit_2, in_data.limit_1, in_data.limit_0};
      in_sum      <= in_data.target_sum;
      colq        <= col;
      par         <= row[0];
      interior_q  <= interior_c;
      row_end_q   <= row_end_c;
      frame_end_q <= frame_end_c;
      jv          <= '0;
      s60         <= '0;
    end
    if (cmd.avg_save) begin
      jv[cmd.chan] <= jv_new;
      if (mode == MODE_BLEND) s60 <= s60 + v60;
    end
    if (cmd.mul_en) prod <= jv[cmd.chan] * held_sum;
    if (cmd.scl_save) jv[cmd.chan] <= q;
    if (cmd.out_load) begin
      out_data.out_0      <= jv[0];
      out_data.out_1      <= jv[1];
      out_data.out_2      <= jv[2];
      out_data.out_3      <= jv[3];
      out_data.written    <= tap_map[TAP_CENTER] != code_none;
      out_data.frame_last <= frame_end_q;
      out_data.updated    <= frame_end_q && (largest > PIX_BITS'(CHANGE_LIMIT));
    end
  end

  always_comb begin
    sts.interior = interior_q;
    sts.covered  = tap_map[TAP_CENTER] != code_none;
    sts.rescale  = (mode == MODE_BLEND) && (s60 != '0);
    sts.na       = na;
    sts.div_done = div_done;
    sts.div_busy = div_busy;
  end

endmodule

>>> design/cbd_ctrl.sv
// controller state machine sequencing reads, averages, rescale and result delivery
// depends on cbd_pkg
module cbd_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output cbd_pkg::cmd_t cmd,
  input  cbd_pkg::sts_t sts
);
  import cbd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_LAST, S_CHECK, S_AVG, S_AVW, S_AVG_END,
    S_MUL, S_SCL, S_SCW, S_CHG, S_DONE
  } state_t;

  state_t               state;
  logic [2:0]           tap;
  logic [CHAN_BITS-1:0] chan;
  logic                 last_chan;

  assign last_chan = (CNT_BITS'(chan) + CNT_BITS'(1)) == sts.na;
  assign in_ready  = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.chan   = chan;
    cmd.rd_tap = tap;
    unique case (state)
      S_IDLE:  cmd.cap_in    = in_valid;
      S_READ:  cmd.rd_en     = 1'b1;
      S_AVG:   cmd.avg_start = 1'b1;
      S_AVW:   cmd.avg_save  = sts.div_done;
      S_MUL:   cmd.mul_en    = 1'b1;
      S_SCL:   cmd.scl_start = 1'b1;
      S_SCW:   cmd.scl_save  = sts.div_done;
      S_CHG:   cmd.chg_en    = 1'b1;
      S_DONE: begin
        cmd.finish   = !(sts.interior && out_valid && !out_ready);
        cmd.out_load = cmd.finish && sts.interior;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      tap       <= '0;
      chan      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            tap   <= TAP_OLD;
            state <= S_READ;
          end
        end
        S_READ: begin
          if (tap == TAP_CENTER) state <= S_LAST;
          else tap <= tap + 1'b1;
        end
        S_LAST:  state <= S_CHECK;
        S_CHECK: begin
          chan <= '0;
          if (sts.interior && sts.covered) state <= S_AVG;
          else state <= S_DONE;
        end
        S_AVG: state <= S_AVW;
        S_AVW: begin
          if (sts.div_done) begin
            if (last_chan) begin
              state <= S_AVG_END;
            end else begin
              chan  <= chan + 1'b1;
              state <= S_AVG;
            end
          end
        end
        S_AVG_END: begin
          chan <= '0;
          if (sts.rescale) state <= S_MUL;
          else state <= S_CHG;
        end
        S_MUL: state <= S_SCL;
        S_SCL: state <= S_SCW;
        S_SCW: begin
          if (sts.div_done) begin
            if (last_chan) begin
              state <= S_CHG;
            end else begin
              chan  <= chan + 1'b1;
              state <= S_MUL;
            end
          end
        end
        S_CHG:  state <= S_DONE;
        S_DONE: if (cmd.finish) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> design/constrained_blend_diffusion_core.sv
// top level of the constrained blend diffusion block
// depends on cbd_pkg, cbd_if, cbd_div, cbd_dp and cbd_ctrl

// Pixels enter in raster order on pix_in. Each accepted pixel at (row r, column c)
// finishes the center pixel (r-1, c-1) when that pixel is interior; border pixels
// give no request on pix_out. The five-point cross average runs per active channel
// over covered neighbors only, is clamped to blend_max, then either forced to the
// limit on single-projector pixels (mode 0) or clamped to the limit and rescaled to
// target_sum (mode 1). frame_last marks the final result of a frame, with updated
// set when the largest change of that frame exceeded 32. One pixel is worked on at
// a time; border and uncovered pixels skip the averages, blending mode adds the
// rescale, and a result may wait on pix_out before the next pixel is finished.
// The work per pixel is bounded by the shared divider, which retires two quotient
// bits per cycle and serves both the averages and the rescale, and by the single
// read port of the line memory, read once per cross tap. A finished result waits
// in the output register while the next pixel is taken in. Configuration must be
// written only while idle, which the block itself does not enforce; no clearing
// pass follows reset.
module constrained_blend_diffusion_core #(
  parameter int MAX_WIDTH = cbd_pkg::MAX_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [cbd_pkg::CFG_IDX_BITS-1:0]  cfg_idx,
  input  logic [cbd_pkg::CFG_DATA_BITS-1:0] cfg_data,
  cbd_in_if.sink                            pix_in,
  cbd_out_if.source                         pix_out
);
  import cbd_pkg::*;

  cmd_t cmd;   // controller to datapath
  sts_t sts;   // datapath to controller

  // sequencing: capture, tap reads, averages, rescale, result
  cbd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pix_in.valid),
    .in_ready  (pix_in.ready),
    .out_valid (pix_out.valid),
    .out_ready (pix_out.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // line memories, arithmetic and the output register
  cbd_dp #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .in_data  (pix_in.data),
    .out_data (pix_out.data),
    .cmd      (cmd),
    .sts      (sts)
  );

`ifndef ASSERT_OFF
  // a pending result is never overwritten
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!pix_out.valid || pix_out.ready))
    else $error("result loaded over a pending request");

  // one pixel at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (pix_in.valid && pix_in.ready) |=> !pix_in.ready)
    else $error("pixel accepted while busy");

  // divider is never restarted mid-division
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.avg_start || cmd.scl_start) |-> !sts.div_busy)
    else $error("divider started while busy");

  // an uncovered center gives all-zero intensities
  a_blank: assert property (@(posedge clk) disable iff (rst)
    (pix_out.valid && !pix_out.data.written) |->
      (pix_out.data.out_0 == '0 && pix_out.data.out_1 == '0 &&
       pix_out.data.out_2 == '0 && pix_out.data.out_3 == '0))
    else $error("uncovered result carries nonzero intensity");
`endif

endmodule
